### sv/ura_pkg.sv
package ura_pkg;

   // Field and register widths.
   localparam int TICK_W     = 20;
   localparam int CM_W       = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // One centimeter of range is 29 us of echo each way, so 58 us round trip.
   localparam int CM_ROUND_TRIP_US = 29 * 2;
   localparam int WIDTH_REM_W      = $clog2(CM_ROUND_TRIP_US);
   localparam logic [WIDTH_REM_W-1:0] WIDTH_REM_LAST =
      WIDTH_REM_W'(CM_ROUND_TRIP_US - 1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAN_TICKS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_CM      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUZZ_TICKS    = 3'd4;

   // Register values after reset.
   localparam logic [TICK_W-1:0] CLEAN_TICKS_RST   = 20'd2000;
   localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST = 20'd5000;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 20'd100;
   localparam logic [CM_W-1:0]   ALERT_CM_RST      = 15'd5;
   localparam logic [TICK_W-1:0] BUZZ_TICKS_RST    = 20'd100000;

   typedef enum logic [2:0] {
      PH_CLEAN = 3'd0,
      PH_TRIG  = 3'd1,
      PH_RISE  = 3'd2,
      PH_HIGH  = 3'd3,
      PH_BUZZ  = 3'd4
   } phase_type;

endpackage

### sv/ura_req_if.sv
interface ura_req_if
   import ura_pkg::*;
;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface

### sv/ura_rsp_if.sv
interface ura_rsp_if
   import ura_pkg::*;
;
   logic            valid;
   logic            ready;
   logic            trigger_level;
   logic            buzzer_level;
   logic            range_valid;
   logic [CM_W-1:0] distance_cm;
   logic            timed_out;
   logic            alert;

   modport source (
      output valid, output trigger_level, output buzzer_level, output range_valid,
      output distance_cm, output timed_out, output alert, input ready
   );
   modport sink (
      input valid, input trigger_level, input buzzer_level, input range_valid,
      input distance_cm, input timed_out, input alert, output ready
   );
endinterface

### sv/ultrasonic_range_alert_unit.sv
// Channel   Dir  Beat contents
// req_chan  in   echo_level: sampled echo pin level, one beat per microsecond tick
// rsp_chan  out  trigger_level, buzzer_level, range_valid, distance_cm, timed_out,
//                alert: exactly one beat for every request beat
// csr_*     in   write enable, register index, 20-bit write data (no read-back)
//
// Every request beat is processed in the cycle it is accepted and its response
// beat appears in the output register on the next cycle, so one beat per cycle
// is sustained unless stalled. The phase register and counters form the only loop.
// A request is taken whenever the output register is empty or being drained.
// Reset (synchronous) returns the sequencer to the clean phase with zero counts,
// clears the last distance and loads the default register values.
module ultrasonic_range_alert_unit
   import ura_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ura_req_if.sink               req_chan,
   ura_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [TICK_W-1:0] clean_ticks_ff, trigger_ticks_ff, timeout_ticks_ff, buzz_ticks_ff;
   logic [CM_W-1:0]   alert_cm_ff;

   // Sequencer state. The echo width is held as a quotient and remainder of the
   // 58 us per centimeter round trip (the count also runs for the timeout), so
   // the distance is ready the moment the echo falls with no divider needed.
   phase_type                phase_ff, phase_in;
   logic [TICK_W-1:0]        count_ff, count_in;
   logic [WIDTH_REM_W-1:0]   width_rem_ff, width_rem_in;
   logic [CM_W-1:0]          width_quo_ff, width_quo_in;
   logic [CM_W-1:0]          last_dist_ff, last_dist_in;

   // Output register.
   logic            rsp_valid_ff;
   logic            trig_ff, buzz_ff, range_ff, tmo_ff, alert_ff;
   logic [CM_W-1:0] dist_ff;

   logic accept;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_ticks_ff   <= CLEAN_TICKS_RST;
         trigger_ticks_ff <= TRIGGER_TICKS_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
         alert_cm_ff      <= ALERT_CM_RST;
         buzz_ticks_ff    <= BUZZ_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CLEAN_TICKS:   clean_ticks_ff   <= csr_wdata;
            CSR_TRIGGER_TICKS: trigger_ticks_ff <= csr_wdata;
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            CSR_ALERT_CM:      alert_cm_ff      <= csr_wdata[CM_W-1:0];
            CSR_BUZZ_TICKS:    buzz_ticks_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Shared conditions of the current tick.
   logic                   echo;
   logic [TICK_W-1:0]      count_inc, timed_limit;
   logic                   timed_done;
   logic [TICK_W-1:0]      pulse_count;
   logic [WIDTH_REM_W-1:0] pulse_rem;
   logic [CM_W-1:0]        pulse_quo;
   logic                   rise_wait, pulse_step, pulse_done, timeout_hit, alert_hit;

   assign echo      = req_chan.echo_level;
   assign count_inc = count_ff + TICK_W'(1);

   always_comb begin
      unique case (phase_ff)
         PH_TRIG: timed_limit = trigger_ticks_ff;
         PH_BUZZ: timed_limit = buzz_ticks_ff;
         default: timed_limit = clean_ticks_ff;
      endcase
   end
   assign timed_done = count_inc >= timed_limit;

   // A rising echo seen in the rise wait is counted as the first pulse tick,
   // starting from cleared pulse counters.
   assign rise_wait   = (phase_ff == PH_RISE) && !echo;
   assign pulse_step  = ((phase_ff == PH_RISE) || (phase_ff == PH_HIGH)) && echo;
   assign pulse_done  = (phase_ff == PH_HIGH) && !echo;
   assign pulse_count = (phase_ff == PH_RISE) ? '0 : count_ff;
   assign pulse_rem   = (phase_ff == PH_RISE) ? '0 : width_rem_ff;
   assign pulse_quo   = (phase_ff == PH_RISE) ? '0 : width_quo_ff;

   assign timeout_hit = (rise_wait && (count_ff == timeout_ticks_ff))
                     || (pulse_step && (pulse_count == timeout_ticks_ff));
   assign alert_hit   = pulse_done && (width_quo_ff != '0) && (width_quo_ff <= alert_cm_ff);

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      width_rem_in = width_rem_ff;
      width_quo_in = width_quo_ff;
      last_dist_in = last_dist_ff;
      unique case (phase_ff)
         PH_CLEAN: begin
            count_in = timed_done ? '0 : count_inc;
            if (timed_done) begin
               phase_in = PH_TRIG;
            end
         end
         PH_TRIG: begin
            count_in = timed_done ? '0 : count_inc;
            if (timed_done) begin
               phase_in     = PH_RISE;
               width_rem_in = '0;
               width_quo_in = '0;
            end
         end
         PH_BUZZ: begin
            count_in = timed_done ? '0 : count_inc;
            if (timed_done) begin
               phase_in = PH_CLEAN;
            end
         end
         PH_RISE, PH_HIGH: begin
            if (timeout_hit) begin
               phase_in     = PH_CLEAN;
               count_in     = '0;
               last_dist_in = '0;
            end else if (pulse_done) begin
               phase_in     = alert_hit ? PH_BUZZ : PH_CLEAN;
               count_in     = '0;
               last_dist_in = width_quo_ff;
            end else if (rise_wait) begin
               count_in = count_inc;
            end else begin
               phase_in = PH_HIGH;
               count_in = pulse_count + TICK_W'(1);
               if (pulse_rem == WIDTH_REM_LAST) begin
                  width_rem_in = '0;
                  width_quo_in = pulse_quo + CM_W'(1);
               end else begin
                  width_rem_in = pulse_rem + WIDTH_REM_W'(1);
                  width_quo_in = pulse_quo;
               end
            end
         end
         default: begin
            // An undefined phase code restarts the clean phase from a zero count.
            phase_in = (TICK_W'(1) >= clean_ticks_ff) ? PH_TRIG : PH_CLEAN;
            count_in = (TICK_W'(1) >= clean_ticks_ff) ? '0 : TICK_W'(1);
         end
      endcase
   end

   // Response fields of the current tick; levels show the phase at its start.
   logic            trig_in, buzz_in, range_in, tmo_in, alert_in;
   logic [CM_W-1:0] dist_in;

   always_comb begin
      trig_in  = (phase_ff == PH_TRIG);
      buzz_in  = (phase_ff == PH_BUZZ);
      range_in = timeout_hit || pulse_done;
      tmo_in   = timeout_hit;
      alert_in = alert_hit && !timeout_hit;
      dist_in  = last_dist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CLEAN;
         count_ff     <= '0;
         width_rem_ff <= '0;
         width_quo_ff <= '0;
         last_dist_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         width_rem_ff <= width_rem_in;
         width_quo_ff <= width_quo_in;
         last_dist_ff <= last_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         trig_ff  <= trig_in;
         buzz_ff  <= buzz_in;
         range_ff <= range_in;
         dist_ff  <= dist_in;
         tmo_ff   <= tmo_in;
         alert_ff <= alert_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.trigger_level = trig_ff;
   assign rsp_chan.buzzer_level  = buzz_ff;
   assign rsp_chan.range_valid   = range_ff;
   assign rsp_chan.distance_cm   = dist_ff;
   assign rsp_chan.timed_out     = tmo_ff;
   assign rsp_chan.alert         = alert_ff;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

// Testbench for the ultrasonic range alert unit.
// Every request beat is one microsecond tick carrying the sampled echo level,
// and the unit answers every request with exactly one response beat. A
// cycle-accurate predictor runs alongside. It is advanced once for each
// request beat at the edge where that beat is accepted, and the response it
// predicts is queued. A separate process pops that queue for each response
// beat taken from the unit and compares all fields.
module testbench
   import ura_pkg::*;
;

   localparam realtime HALF_PERIOD = 6ns;

   // Indexes above the last register must be ignored by the unit.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_BUZZ_TICKS + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = '1;

   // One response beat, with the fields in the order the unit reports them.
   typedef struct packed {
      logic            trigger_level;
      logic            buzzer_level;
      logic            range_valid;
      logic [CM_W-1:0] distance_cm;
      logic            timed_out;
      logic            alert;
   } range_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ura_req_if req ();
   ura_rsp_if rsp ();

   ultrasonic_range_alert_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Register copies that the predictor works from.
   logic [TICK_W-1:0] cfg_clean;
   logic [TICK_W-1:0] cfg_trigger;
   logic [TICK_W-1:0] cfg_timeout;
   logic [CM_W-1:0]   cfg_alert;
   logic [TICK_W-1:0] cfg_buzz;

   // Predicted sequencer state.
   phase_type         rg_phase;
   logic [TICK_W-1:0] rg_count;
   logic [TICK_W-1:0] rg_width;
   logic [CM_W-1:0]   rg_distance;

   // Responses predicted but not yet seen, oldest first.
   range_beat_type expected_beats[$];
   range_beat_type seen_beat;
   range_beat_type want_beat;

   // Idling control. The percentages give the chance, drawn at each falling edge,
   // that the sender stays idle or that the receiver holds ready low.
   int src_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int hold_cycles   = 0;

   int fail_count    = 0;
   int ticks_sent    = 0;
   int ranges_done   = 0;
   int timeouts_seen = 0;
   int alerts_seen   = 0;

   // Advances a timed phase (clean, trigger or buzz) by one tick. The phase
   // ends when the count reaches its register, so a register of zero behaves
   // like one.
   function automatic logic count_done(input logic [TICK_W-1:0] limit);
      rg_count = rg_count + 1'b1;
      if (rg_count >= limit) begin
         rg_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Predicts the response to one echo tick and advances the state. The
   // trigger and buzzer levels reflect the phase held at the start of the tick.
   function automatic range_beat_type tick_ranger(input logic echo);
      range_beat_type beat;
      logic           tmo;
      beat = '0;
      tmo  = 1'b0;
      beat.trigger_level = (rg_phase == PH_TRIG);
      beat.buzzer_level  = (rg_phase == PH_BUZZ);
      case (rg_phase)
         PH_CLEAN: begin
            if (count_done(cfg_clean)) rg_phase = PH_TRIG;
         end
         PH_TRIG: begin
            if (count_done(cfg_trigger)) begin
               rg_phase = PH_RISE;
               rg_width = '0;
            end
         end
         PH_BUZZ: begin
            if (count_done(cfg_buzz)) rg_phase = PH_CLEAN;
         end
         default: begin
            // Waiting for the echo to rise. A high tick starts the pulse and
            // is counted as part of it on the same tick.
            if (rg_phase == PH_RISE) begin
               if (echo) begin
                  rg_phase = PH_HIGH;
                  rg_count = '0;
                  rg_width = '0;
               end else if (rg_count == cfg_timeout) begin
                  tmo = 1'b1;
               end else begin
                  rg_count = rg_count + 1'b1;
               end
            end
            // Timing the pulse. The first low tick ends the measurement.
            if (rg_phase == PH_HIGH && !tmo) begin
               if (echo) begin
                  if (rg_count == cfg_timeout) begin
                     tmo = 1'b1;
                  end else begin
                     rg_count = rg_count + 1'b1;
                     rg_width = rg_width + 1'b1;
                  end
               end else begin
                  beat.range_valid = 1'b1;
                  rg_distance = CM_W'(rg_width / CM_ROUND_TRIP_US);
                  beat.alert = (rg_distance != '0) && (rg_distance <= cfg_alert);
                  if (beat.alert) rg_phase = PH_BUZZ;
                  else rg_phase = PH_CLEAN;
                  rg_count = '0;
               end
            end
            // Either wait running out reports a zero distance and restarts.
            if (tmo) begin
               beat.range_valid = 1'b1;
               rg_distance = '0;
               rg_phase = PH_CLEAN;
               rg_count = '0;
            end
         end
      endcase
      beat.distance_cm = rg_distance;
      beat.timed_out   = tmo;
      return beat;
   endfunction

   // Receiver side. Ready changes at the falling edge. A long hold requested
   // by a test overrides the random stalls and is counted down here at each
   // falling edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp.ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
         hold_cycles = hold_cycles + 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Response checker. A beat is taken at a rising edge with valid and ready
   // both high and is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         seen_beat.trigger_level = rsp.trigger_level;
         seen_beat.buzzer_level  = rsp.buzzer_level;
         seen_beat.range_valid   = rsp.range_valid;
         seen_beat.distance_cm   = rsp.distance_cm;
         seen_beat.timed_out     = rsp.timed_out;
         seen_beat.alert         = rsp.alert;
         if (expected_beats.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: unpredicted beat: trig=%0b buzz=%0b valid=%0b",
                        $realtime, seen_beat.trigger_level, seen_beat.buzzer_level,
                        seen_beat.range_valid);
            fail_count = fail_count + 1;
         end else begin
            want_beat = expected_beats.pop_front();
            if (seen_beat !== want_beat) begin
               if (fail_count < 10) begin
                  $display("%0t: expected trig=%0b buzz=%0b valid=%0b cm=%0d tmo=%0b alert=%0b",
                           $realtime, want_beat.trigger_level, want_beat.buzzer_level,
                           want_beat.range_valid, want_beat.distance_cm,
                           want_beat.timed_out, want_beat.alert);
                  $display("%0t: actual   trig=%0b buzz=%0b valid=%0b cm=%0d tmo=%0b alert=%0b",
                           $realtime, seen_beat.trigger_level, seen_beat.buzzer_level,
                           seen_beat.range_valid, seen_beat.distance_cm,
                           seen_beat.timed_out, seen_beat.alert);
               end
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // Offers one echo tick. It is entered at a falling edge and returns at the
   // falling edge after the beat was accepted, with valid still high, so the
   // next call can keep valid up without a gap.
   task automatic send_echo_tick(input logic echo);
      range_beat_type beat;
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.echo_level <= echo;
      do @(posedge clock); while (!req.ready);
      beat = tick_ranger(echo);
      expected_beats.push_back(beat);
      ticks_sent = ticks_sent + 1;
      if (beat.range_valid) begin
         if (beat.timed_out) timeouts_seen = timeouts_seen + 1;
         else ranges_done = ranges_done + 1;
      end
      if (beat.alert) alerts_seen = alerts_seen + 1;
      @(negedge clock);
   endtask

   // Sends a fixed echo pattern, least significant bit first.
   task automatic send_echo_pattern(input logic [31:0] levels, input int count);
      for (int i = 0; i < count; i++) send_echo_tick(levels[i]);
   endtask

   // Drops valid, waits until every predicted beat has come back, and then lets
   // the one-deep output register settle.
   task automatic wait_for_quiet();
      req.valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register write. The enable is left high so that writes can follow
   // back to back; the caller lowers it after the last one.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      case (idx)
         CSR_CLEAN_TICKS:   cfg_clean   = data;
         CSR_TRIGGER_TICKS: cfg_trigger = data;
         CSR_TIMEOUT_TICKS: cfg_timeout = data;
         CSR_ALERT_CM:      cfg_alert   = data[CM_W-1:0];
         CSR_BUZZ_TICKS:    cfg_buzz    = data;
         default: ;
      endcase
   endtask

   task automatic set_ranger(input logic [CSR_DATA_W-1:0] clean_val,
                             input logic [CSR_DATA_W-1:0] trigger_val,
                             input logic [CSR_DATA_W-1:0] timeout_val,
                             input logic [CSR_DATA_W-1:0] alert_val,
                             input logic [CSR_DATA_W-1:0] buzz_val);
      write_csr(CSR_CLEAN_TICKS, clean_val);
      write_csr(CSR_TRIGGER_TICKS, trigger_val);
      write_csr(CSR_TIMEOUT_TICKS, timeout_val);
      write_csr(CSR_ALERT_CM, alert_val);
      write_csr(CSR_BUZZ_TICKS, buzz_val);
      csr_we <= 1'b0;
   endtask

   // Random pings. In the echo wait phases a planned echo is played back: a
   // low gap, then a high pulse of chosen width. Most pulses are short
   // (zero distance), many are long enough to give a distance and possibly an
   // alert, and some gaps or pulses outlast the timeout. A few pings get pure
   // noise instead. Outside the waits the echo is low with stray high ticks.
   // The loop runs until the item count is reached and enough measurements
   // have completed, with a hard cap on the number of ticks.
   task automatic run_pings(input int n_items, input int min_ranges);
      int   sent;
      int   first_range;
      int   gap_left;
      int   width_left;
      int   pick;
      bit   planned;
      bit   noisy;
      logic echo;
      sent        = 0;
      first_range = ranges_done;
      gap_left    = 0;
      width_left  = 0;
      planned     = 1'b0;
      noisy       = 1'b0;
      while (sent < 3 * n_items &&
             (sent < n_items || ranges_done - first_range < min_ranges)) begin
         if (rg_phase == PH_RISE || rg_phase == PH_HIGH) begin
            if (!planned) begin
               planned = 1'b1;
               noisy   = ($urandom_range(99) < 8);
               // Outlasting a wait is only planned while the timeout is short.
               if (cfg_timeout < 500 && $urandom_range(99) < 15)
                  gap_left = int'(cfg_timeout) + 1 + $urandom_range(3);
               else
                  gap_left = $urandom_range(20);
               pick = $urandom_range(99);
               if (pick < 65)
                  width_left = $urandom_range(57, 1);
               else if (pick < 95 || cfg_timeout >= 500)
                  width_left = $urandom_range(420, 58);
               else
                  width_left = int'(cfg_timeout) + 1 + $urandom_range(4);
            end
            if (noisy) begin
               echo = 1'($urandom_range(1));
            end else if (gap_left > 0) begin
               echo = 1'b0;
               gap_left = gap_left - 1;
            end else if (width_left > 0) begin
               echo = 1'b1;
               width_left = width_left - 1;
            end else begin
               echo = 1'b0;
            end
         end else begin
            planned = 1'b0;
            echo = ($urandom_range(15) == 0);
         end
         send_echo_tick(echo);
         sent = sent + 1;
      end
      wait_for_quiet();
   endtask

   // Right after reset the default registers hold the trigger low for a long
   // clean time, so the two ticks sent see only the clean phase.
   task automatic test_reset_defaults();
      send_echo_pattern(32'b01, 2);
      wait_for_quiet();
   endtask

   // Tiny timings walk whole cycles: a rise wait that runs out, a short pulse
   // that completes with zero distance, a pulse that outlasts its timeout, and
   // a zero timeout that gives up on the first tick of either wait. The clean
   // register is zero, which acts like one. Echo high in the clean and trigger
   // phases must be ignored.
   task automatic test_short_cycles();
      set_ranger(20'd0, 20'd1, 20'd3, 20'd5, 20'd2);
      send_echo_pattern(32'b000011, 6);
      send_echo_pattern(32'b01100, 5);
      send_echo_pattern(32'b111100, 6);
      wait_for_quiet();
      write_csr(CSR_TIMEOUT_TICKS, 20'd0);
      csr_we <= 1'b0;
      send_echo_pattern(32'b100000, 6);
      wait_for_quiet();
   endtask

   // Every register at its all-ones value, and writes to the unused indexes,
   // which must change nothing. Lowering a limit below a running count ends
   // that phase on the next tick.
   task automatic test_register_extremes();
      set_ranger('1, '1, '1, '1, '1);
      for (int idx = CSR_SPARE_FIRST; idx <= CSR_SPARE_LAST; idx++)
         write_csr(CSR_IDX_W'(idx), 20'h5A5A5 ^ CSR_DATA_W'(idx));
      csr_we <= 1'b0;
      send_echo_pattern(32'b101, 3);
      wait_for_quiet();
      write_csr(CSR_CLEAN_TICKS, 20'd1);
      csr_we <= 1'b0;
      send_echo_pattern(32'b010, 3);
      wait_for_quiet();
      write_csr(CSR_TRIGGER_TICKS, 20'd1);
      csr_we <= 1'b0;
      send_echo_pattern(32'b100, 3);
      wait_for_quiet();
   endtask

   // The receiver holds ready low for a long stretch while the sender keeps
   // offering ticks, so the output register fills and the input is stalled.
   task automatic test_backpressure();
      set_ranger(20'd2, 20'd2, 20'd100, 20'd4, 20'd3);
      src_idle_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 80;
      run_pings(40, 0);
   endtask

   // Random pings under each idling mode, each with its own settings. Between
   // them the alert threshold covers zero and a large value, the timeout goes
   // from short to very long, and stray upper write bits on the narrower alert
   // register are dropped.
   task automatic test_random_pings();
      src_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_ranger(CSR_DATA_W'($urandom_range(3, 1)), CSR_DATA_W'($urandom_range(3, 1)),
                 20'd300, {5'($urandom), 15'd17241},
                 CSR_DATA_W'($urandom_range(10, 1)));
      run_pings(220, 10);

      src_idle_pct  = 78;
      rsp_stall_pct = 0;
      set_ranger(CSR_DATA_W'($urandom_range(4, 1)), CSR_DATA_W'($urandom_range(4, 1)),
                 CSR_DATA_W'($urandom_range(80, 20)), 20'd0,
                 CSR_DATA_W'($urandom_range(10, 1)));
      run_pings(220, 10);

      src_idle_pct  = 0;
      rsp_stall_pct = 78;
      set_ranger(CSR_DATA_W'($urandom_range(4, 1)), CSR_DATA_W'($urandom_range(4, 1)),
                 20'd200, 20'd3, CSR_DATA_W'($urandom_range(20, 1)));
      run_pings(220, 10);

      src_idle_pct  = 17;
      rsp_stall_pct = 17;
      set_ranger(CSR_DATA_W'($urandom_range(4, 1)), CSR_DATA_W'($urandom_range(4, 1)),
                 20'd1000000, CSR_DATA_W'($urandom_range(7, 1)),
                 CSR_DATA_W'($urandom_range(20, 1)));
      run_pings(220, 10);
   endtask

   initial begin
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.echo_level = 1'b0;
      rsp.ready      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_CLEAN_TICKS;
      csr_wdata      = '0;

      // The predictor starts from the reset state of the unit.
      cfg_clean   = CLEAN_TICKS_RST;
      cfg_trigger = TRIGGER_TICKS_RST;
      cfg_timeout = TIMEOUT_TICKS_RST;
      cfg_alert   = ALERT_CM_RST;
      cfg_buzz    = BUZZ_TICKS_RST;
      rg_phase    = PH_CLEAN;
      rg_count    = '0;
      rg_width    = '0;
      rg_distance = '0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_short_cycles();
      test_register_extremes();
      test_backpressure();
      test_random_pings();
      wait_for_quiet();

      // Anything still predicted at this point never arrived.
      fail_count = fail_count + expected_beats.size();
      $display("Checked %0d echo ticks: %0d ranges measured, %0d echo timeouts, %0d alerts.",
               ticks_sent, ranges_done, timeouts_seen, alerts_seen);
      $display("Covered register extremes, unused indexes, four idling modes and a %0d-cycle hold.",
               hold_cycles);
      if (fail_count == 0) begin
         $display("ultrasonic_range_alert_unit: match");
      end else begin
         $display("ultrasonic_range_alert_unit: mismatch");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this time.
   initial begin
      #10ms;
      $display("ultrasonic_range_alert_unit: mismatch");
      $finish;
   end

endmodule

### filelist.f
sv/ura_pkg.sv
sv/ura_req_if.sv
sv/ura_rsp_if.sv
sv/ultrasonic_range_alert_unit.sv
tb/sv/testbench.sv
